>>> rtl/egexp_pkg.sv
// Package for the ExpGaussExp line-shape pipeline: formats, codes and the 2^-f table.
package egexp_pkg;

  localparam int EXP_TABLE_BITS = 8;
  localparam int TAB_N          = 1 << EXP_TABLE_BITS;
  localparam int FRAC_W         = 16;                  // fraction bits of y
  localparam int INTERP_W       = FRAC_W - EXP_TABLE_BITS;
  localparam int Q_BITS         = 24;                  // quotient bits before saturation
  localparam int DIV_STAGES     = Q_BITS;

  localparam longint unsigned ONE_Q30   = 64'd1073741824;
  localparam longint unsigned LOG2E_Q30 = 64'd1549082005;
  localparam longint unsigned LN2_Q30   = 64'd744261118;

  typedef logic [31:0] sample_t;
  typedef logic [16:0] density_t;
  typedef logic [1:0]  region_t;
  typedef logic [1:0]  cfg_idx_t;
  typedef logic [30:0] rom_word_t;

  localparam region_t REGION_LOW  = 2'd0;
  localparam region_t REGION_CORE = 2'd1;
  localparam region_t REGION_HIGH = 2'd2;

  localparam cfg_idx_t CFG_CENTRE = 2'd0;
  localparam cfg_idx_t CFG_WIDTH  = 2'd1;
  localparam cfg_idx_t CFG_KLO    = 2'd2;
  localparam cfg_idx_t CFG_KHI    = 2'd3;

  // truncating quotient by shift and subtract; elaboration only
  function automatic longint unsigned div_trunc(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 64'd1);
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | (64'd1 << b);
      end
    end
    return quo;
  endfunction

  // 2^(-idx/TAB_N) in Q30 from a truncated Taylor series of exp(-z); elaboration only
  function automatic rom_word_t pow2_entry(input int unsigned idx);
    longint unsigned z;
    longint unsigned term;
    longint          sum;
    z    = (longint'(idx) * LN2_Q30) >> EXP_TABLE_BITS;
    term = ONE_Q30;
    sum  = longint'(ONE_Q30);
    for (int k = 1; k <= 16; k++) begin
      term = div_trunc((term * z) >> 30, longint'(k));
      if ((k & 1) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
    return rom_word_t'(sum);
  endfunction

endpackage

>>> rtl/exp_gauss_exp_density.sv
// ExpGaussExp line shape: divider pipeline, region select and table-based exp.
// Throughput: one word per cycle; the 24-stage restoring divider (one quotient bit
// per stage) sets the depth, the whole pipeline holds while the output is stalled.
// Reset: synchronous, active low; clears all stage valid bits and loads the register
// defaults (centre 0, width 1.0, both tail constants 1.5).
module exp_gauss_exp_density (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  egexp_pkg::cfg_idx_t cfg_idx,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  egexp_pkg::sample_t  in_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output egexp_pkg::density_t out_density,
  output egexp_pkg::region_t  out_region
);
  import egexp_pkg::*;

  localparam int NST    = DIV_STAGES + 7;
  localparam int S_REG  = DIV_STAGES + 1;
  localparam int S_PROD = DIV_STAGES + 2;
  localparam int S_Y    = DIV_STAGES + 3;
  localparam int S_ROM  = DIV_STAGES + 4;
  localparam int S_V    = DIV_STAGES + 5;
  localparam int S_OUT  = DIV_STAGES + 6;

  // configuration registers
  logic [31:0] centre_r;
  logic [30:0] width_r;
  logic [23:0] klo_r;
  logic [23:0] khi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_r <= 32'd0;
      width_r  <= 31'd65536;
      klo_r    <= 24'd98304;
      khi_r    <= 24'd98304;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_CENTRE: centre_r <= cfg_wdata;
        CFG_WIDTH:  width_r  <= cfg_wdata[30:0];
        CFG_KLO:    klo_r    <= cfg_wdata[23:0];
        CFG_KHI:    khi_r    <= cfg_wdata[23:0];
        default:    ;
      endcase
    end
  end

  logic [30:0] w_eff;
  assign w_eff = (width_r == 31'd0) ? 31'd1 : width_r;

  // constant 2^-f table
  rom_word_t rom_tab [0:TAB_N];
  for (genvar g = 0; g <= TAB_N; g++) begin : g_rom
    localparam rom_word_t EV = pow2_entry(g);
    assign rom_tab[g] = EV;
  end

  logic adv;
  logic [NST-1:0] vld_r;
  assign adv      = !vld_r[S_OUT] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NST-2:0], in_valid};
  end

  // stage 0: difference, magnitude, quotient overflow
  logic [32:0] diff_s;
  logic [32:0] mag_s;
  assign diff_s = {in_sample[31], in_sample} - {centre_r[31], centre_r};
  assign mag_s  = diff_s[32] ? (33'd0 - diff_s) : diff_s;

  logic [30:0]       rem_r  [0:DIV_STAGES];
  logic [7:0]        mlo_r  [0:DIV_STAGES];
  logic [Q_BITS-1:0] q_r    [0:DIV_STAGES];
  logic              neg_r  [0:DIV_STAGES];
  logic              ovf_r  [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= {6'd0, mag_s[32:8]};
      mlo_r[0] <= mag_s[7:0];
      q_r[0]   <= '0;
      neg_r[0] <= diff_s[32];
      ovf_r[0] <= {6'd0, mag_s} >= {w_eff, 8'd0};
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
    localparam int K = DIV_STAGES - j;
    logic        nb;
    logic [31:0] cand;
    logic [31:0] sub;
    logic        ge;
    if (K >= 16) begin : g_nb
      assign nb = mlo_r[j-1][K-16];
    end else begin : g_zero
      assign nb = 1'b0;
    end
    assign cand = {rem_r[j-1], nb};
    assign ge   = cand >= {1'b0, w_eff};
    assign sub  = cand - {1'b0, w_eff};
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j] <= ge ? sub[30:0] : cand[30:0];
        mlo_r[j] <= mlo_r[j-1];
        neg_r[j] <= neg_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
        q_r[j]   <= q_r[j-1] | (ge ? (Q_BITS'(1) << K) : '0);
      end
    end
  end

  // saturate t, pick region and product operands
  localparam logic [Q_BITS-1:0] TMAX = Q_BITS'(1) << (Q_BITS - 1);
  logic [Q_BITS-1:0] qs;
  logic signed [25:0] t_s;
  logic signed [25:0] klo_s;
  logic signed [25:0] khi_s;
  logic signed [25:0] blo_s;
  logic signed [25:0] bhi_s;
  logic [23:0] abs_t;
  region_t     reg_nxt;
  logic [23:0] a_nxt;
  logic [24:0] b_nxt;

  always_comb begin
    logic [Q_BITS-1:0] qd;
    qd = q_r[DIV_STAGES];
    if (neg_r[DIV_STAGES]) qs = (ovf_r[DIV_STAGES] || qd > TMAX) ? TMAX : qd;
    else qs = (ovf_r[DIV_STAGES] || qd > TMAX - 1'b1) ? TMAX - 1'b1 : qd;
  end

  assign t_s   = neg_r[DIV_STAGES] ? (26'sd0 - $signed({2'b00, qs})) : $signed({2'b00, qs});
  assign klo_s = $signed({2'b00, klo_r});
  assign khi_s = $signed({2'b00, khi_r});
  assign blo_s = 26'sd0 - (t_s <<< 1) - klo_s;
  assign bhi_s = (t_s <<< 1) - khi_s;
  assign abs_t = qs;

  always_comb begin
    priority if (t_s + klo_s <= 26'sd0) begin
      reg_nxt = REGION_LOW;
      a_nxt   = klo_r;
      b_nxt   = blo_s[24:0];
    end else if (t_s > khi_s) begin
      reg_nxt = REGION_HIGH;
      a_nxt   = khi_r;
      b_nxt   = bhi_s[24:0];
    end else begin
      reg_nxt = REGION_CORE;
      a_nxt   = abs_t;
      b_nxt   = {1'b0, abs_t};
    end
  end

  region_t     reg_r [S_REG:S_OUT];
  logic [23:0] a_r;
  logic [24:0] b_r;
  logic [48:0] p_r;
  logic [21:0] y_r;
  logic        zero_y_r;
  rom_word_t   rv_r;
  rom_word_t   dif_r;
  logic [INTERP_W-1:0] fr_r;
  logic [5:0]  n_rom_r;
  logic        zero_rom_r;
  rom_word_t   v_r;
  logic [5:0]  n_v_r;
  logic        zero_v_r;
  density_t    dens_r;

  // exponent argument and log2(e) scaling
  localparam logic [48:0] LIM = 49'd1 << 37;
  logic [51:0] ymul;
  assign ymul = {31'd0, p_r[37:17]} * 52'(LOG2E_Q30);

  logic [EXP_TABLE_BITS-1:0] ti;
  logic [EXP_TABLE_BITS:0]   ti1;
  rom_word_t r0;
  rom_word_t r1;
  assign ti  = y_r[FRAC_W-1 -: EXP_TABLE_BITS];
  assign ti1 = {1'b0, ti} + 1'b1;
  assign r0  = rom_tab[ti];
  assign r1  = rom_tab[ti1];

  logic [30+INTERP_W:0] imul;
  rom_word_t ioff;
  assign imul = dif_r * fr_r;
  assign ioff = imul[30+INTERP_W:INTERP_W];

  logic [39:0] rsum;
  logic [39:0] rsh;
  logic [6:0]  sh1;
  assign sh1  = {1'b0, n_v_r} + 7'd13;
  assign rsum = {9'd0, v_r} + (40'd1 << sh1);
  assign rsh  = rsum >> (sh1 + 7'd1);

  always_ff @(posedge clk) begin
    if (adv) begin
      reg_r[S_REG] <= reg_nxt;
      a_r          <= a_nxt;
      b_r          <= b_nxt;
      // S_PROD
      reg_r[S_PROD] <= reg_r[S_REG];
      p_r           <= {25'd0, a_r} * {24'd0, b_r};
      // S_Y
      reg_r[S_Y] <= reg_r[S_PROD];
      zero_y_r   <= p_r > LIM;
      y_r        <= ymul[51:30];
      // S_ROM
      reg_r[S_ROM] <= reg_r[S_Y];
      rv_r         <= r0;
      dif_r        <= (r0 > r1) ? (r0 - r1) : '0;
      fr_r         <= y_r[INTERP_W-1:0];
      n_rom_r      <= y_r[21:16];
      zero_rom_r   <= zero_y_r;
      // S_V
      reg_r[S_V] <= reg_r[S_ROM];
      v_r        <= rv_r - ioff;
      n_v_r      <= n_rom_r;
      zero_v_r   <= zero_rom_r;
      // S_OUT: drop deep-tail words to zero
      reg_r[S_OUT] <= reg_r[S_V];
      dens_r       <= zero_v_r ? '0 : rsh[16:0];
    end
  end

  assign out_valid   = vld_r[S_OUT];
  assign out_density = dens_r;
  assign out_region  = reg_r[S_OUT];

endmodule
